FILE: src/bpa_pkg.sv
// Shared constants, codes and types for the bitmap page allocator.
// Used by the channel interfaces, the word unit, the bitmap RAM and the core.
package bpa_pkg;

  localparam int unsigned BITMAP_WORDS = 1024;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BIT_W        = $clog2(WORD_W);
  localparam int unsigned RANGE_W      = BIT_W + 1;
  localparam int unsigned WADDR_W      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned TOTAL_BLOCKS = BITMAP_WORDS * WORD_W;
  localparam int unsigned IDX_W        = WADDR_W + BIT_W;
  localparam int unsigned CNT_W        = $clog2(TOTAL_BLOCKS + 1);

  // Field widths of the channel words and the configuration register
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned PAGE_W = 32;
  localparam int unsigned BCNT_W = 16;
  localparam int unsigned FREE_W = 16;
  localparam int unsigned NEXT_W = 15;
  localparam int unsigned MAXB_W = 16;

  localparam logic [MAXB_W-1:0] MAX_BLOCKS_RST = 16'h8000;

  typedef enum logic [CMD_W-1:0] {
    CMD_FORMAT  = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_RESERVE = 3'd2,
    CMD_FREE    = 3'd3,
    CMD_GROW    = 3'd4
  } cmd_e;

  typedef enum logic {
    ST_OK      = 1'b0,
    ST_NO_FREE = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    WOP_FILL = 2'd0,
    WOP_SET  = 2'd1,
    WOP_CLR  = 2'd2
  } word_op_e;

  // Operation on one bitmap word: bits in [lo, hi) form the mask
  typedef struct packed {
    word_op_e           op;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
  } word_op_t;

  typedef struct packed {
    logic [WORD_W-1:0] wdata;
    logic              old_bit;
    logic              any_zero;
    logic [BIT_W-1:0]  zero_pos;
  } word_res_t;

endpackage

FILE: src/bpa_cmd_if.sv
// Command channel of the bitmap page allocator: valid/ready plus command word.
// Depends on bpa_pkg for the field widths.
interface bpa_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [bpa_pkg::CMD_W-1:0]  command;
  logic [bpa_pkg::PAGE_W-1:0] page_number;
  logic [bpa_pkg::BCNT_W-1:0] block_count;

  modport source (output valid, command, page_number, block_count, input ready);
  modport sink   (input valid, command, page_number, block_count, output ready);
endinterface

FILE: src/bpa_rsp_if.sv
// Response channel of the bitmap page allocator: valid/ready plus result word.
// Depends on bpa_pkg for the field widths.
interface bpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [bpa_pkg::PAGE_W-1:0] allocated_page;
  logic [bpa_pkg::BCNT_W-1:0] surplus_blocks;
  logic [bpa_pkg::FREE_W-1:0] free_count;
  logic [bpa_pkg::NEXT_W-1:0] next_free;
  logic                       none_free;

  modport source (output valid, status, allocated_page, surplus_blocks, free_count,
                  next_free, none_free, input ready);
  modport sink   (input valid, status, allocated_page, surplus_blocks, free_count,
                  next_free, none_free, output ready);
endinterface

FILE: src/bpa_ram.sv
// Usage bitmap storage: one write port, one read port with registered data.
// Depends on bpa_pkg for depth and word width.
module bpa_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [bpa_pkg::WADDR_W-1:0]  waddr_i,
  input  logic [bpa_pkg::WORD_W-1:0]   wdata_i,
  input  logic [bpa_pkg::WADDR_W-1:0]  raddr_i,
  output logic [bpa_pkg::WORD_W-1:0]   rdata_o
);

  logic [bpa_pkg::WORD_W-1:0] mem_q [bpa_pkg::BITMAP_WORDS];
  logic [bpa_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bpa_word_unit.sv
// Shared word unit: range mask, fill/set/clear of a bitmap word, first-zero find.
// Depends on bpa_pkg for word_op_t and word_res_t.
module bpa_word_unit (
  input  bpa_pkg::word_op_t           op_i,
  input  logic [bpa_pkg::WORD_W-1:0]  rdata_i,
  output bpa_pkg::word_res_t          res_o
);

  logic [bpa_pkg::WORD_W-1:0] lo_m;
  logic [bpa_pkg::WORD_W-1:0] hi_m;
  logic [bpa_pkg::WORD_W-1:0] mask;

  always_comb begin
    lo_m = (op_i.lo >= bpa_pkg::RANGE_W'(bpa_pkg::WORD_W)) ? '0 :
           ({bpa_pkg::WORD_W{1'b1}} << op_i.lo[bpa_pkg::BIT_W-1:0]);
    hi_m = (op_i.hi >= bpa_pkg::RANGE_W'(bpa_pkg::WORD_W)) ? '0 :
           ({bpa_pkg::WORD_W{1'b1}} << op_i.hi[bpa_pkg::BIT_W-1:0]);
    mask = lo_m & ~hi_m;

    case (op_i.op)
      bpa_pkg::WOP_SET: res_o.wdata = rdata_i | mask;
      bpa_pkg::WOP_CLR: res_o.wdata = rdata_i & ~mask;
      default:          res_o.wdata = ~mask;
    endcase

    res_o.old_bit  = |(rdata_i & mask);
    res_o.any_zero = ~&rdata_i;

    // lowest clear bit wins
    res_o.zero_pos = '0;
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!rdata_i[i]) begin
        res_o.zero_pos = bpa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

FILE: src/bitmap_page_allocator_core.sv
// Bitmap page allocator: sequencer over the usage bitmap RAM and the word unit.
// Depends on bpa_pkg, bpa_cmd_if, bpa_rsp_if, bpa_ram and bpa_word_unit.
//
// Usage: one command word enters on cmd_i (format, allocate, reserve, free,
// grow); exactly one result word leaves on rsp_o. cfg_we_i/cfg_wdata_i write
// the grow limit (max managed blocks); the user must write it only while the
// block is idle, which the core does not enforce. The core works on one
// command at a time; cmd_i.ready is high only when idle. Steps per command:
//   format:            one word written per cycle over all BITMAP_WORDS words
//   free, or no-op:    read, modify-write, finish
//   allocate, reserve: as free, plus a read/check per word scanned if the taken
//                      block was the lowest free one (rescan starts at its word)
//   grow:              room, set-up, read, modify-write per bitmap word touched
//   no free block, out-of-range page, unknown command: straight to finish
// After reset a clearing pass writes all BITMAP_WORDS words to "used", one per
// cycle; no command is accepted until it ends.
// The result sits in an output register. If the receiver stalls, a finished
// command waits in the finish state until the register frees up, while a new
// command can be accepted in the cycle after the previous result is loaded.
module bitmap_page_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpa_pkg::MAXB_W-1:0]  cfg_wdata_i,
  bpa_cmd_if.sink                     cmd_i,
  bpa_rsp_if.source                   rsp_o
);

  typedef enum logic [9:0] {
    S_INIT     = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_FMT      = 10'b00_0000_0100,
    S_RD       = 10'b00_0000_1000,
    S_RMW      = 10'b00_0001_0000,
    S_GROOM    = 10'b00_0010_0000,
    S_GSET     = 10'b00_0100_0000,
    S_SCAN_RD  = 10'b00_1000_0000,
    S_SCAN_CHK = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_e;

  localparam int unsigned WADDR_W = bpa_pkg::WADDR_W;
  localparam int unsigned IDX_W   = bpa_pkg::IDX_W;
  localparam int unsigned CNT_W   = bpa_pkg::CNT_W;
  localparam int unsigned BIT_W   = bpa_pkg::BIT_W;
  localparam int unsigned RANGE_W = bpa_pkg::RANGE_W;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(bpa_pkg::BITMAP_WORDS - 1);

  state_e                     state_q, state_d;
  logic [WADDR_W-1:0]         word_q, word_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [IDX_W-1:0]           last_q, last_d;
  logic [bpa_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [CNT_W-1:0]           fmt_n_q, fmt_n_d;
  logic [bpa_pkg::BCNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0]           room_q, room_d;
  logic [bpa_pkg::PAGE_W-1:0] base_q, base_d;
  logic [CNT_W-1:0]           managed_q, managed_d;
  logic [CNT_W-1:0]           free_q, free_d;
  logic [IDX_W-1:0]           hint_q, hint_d;
  logic                       hint_valid_q, hint_valid_d;
  logic [bpa_pkg::MAXB_W-1:0] max_q, max_d;
  bpa_pkg::status_e           status_q, status_d;
  logic [bpa_pkg::PAGE_W-1:0] alloc_q, alloc_d;
  logic [bpa_pkg::BCNT_W-1:0] surplus_q, surplus_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_status_q;
  logic [bpa_pkg::PAGE_W-1:0] out_alloc_q;
  logic [bpa_pkg::BCNT_W-1:0] out_surplus_q;
  logic [bpa_pkg::FREE_W-1:0] out_free_q;
  logic [bpa_pkg::NEXT_W-1:0] out_next_q;
  logic                       out_none_q;

  logic                       accept;
  logic                       out_load;
  logic [CNT_W-1:0]           fmt_n;
  logic [bpa_pkg::PAGE_W-1:0] page_off;
  logic                       page_in_range;
  logic [CNT_W-1:0]           limit;
  logic [CNT_W-1:0]           room;
  logic [CNT_W-1:0]           grow_add;
  logic [CNT_W-1:0]           grow_end;
  logic [IDX_W-1:0]           grow_start;
  logic [CNT_W-1:0]           fmt_word;
  logic [RANGE_W-1:0]         fmt_hi;
  logic [RANGE_W-1:0]         grow_lo;
  logic [RANGE_W-1:0]         grow_hi;
  logic                       is_grow;
  logic                       bit_changed;

  bpa_pkg::word_op_t          wop;
  bpa_pkg::word_res_t         wres;
  logic                       mem_we;
  logic [bpa_pkg::WORD_W-1:0] mem_rdata;

  bpa_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (word_q),
    .wdata_i (wres.wdata),
    .raddr_i (word_q),
    .rdata_o (mem_rdata)
  );

  bpa_word_unit u_word_unit (
    .op_i    (wop),
    .rdata_i (mem_rdata),
    .res_o   (wres)
  );

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);
  assign is_grow     = (cmd_q == bpa_pkg::CMD_GROW);

  // Datapath terms
  always_comb begin
    fmt_n = (32'(cmd_i.block_count) > 32'(bpa_pkg::TOTAL_BLOCKS)) ?
            CNT_W'(bpa_pkg::TOTAL_BLOCKS) : CNT_W'(cmd_i.block_count);
    // page - base - 1
    page_off      = cmd_i.page_number + ~base_q;
    page_in_range = page_off < 32'(managed_q);

    limit = (32'(max_q) > 32'(bpa_pkg::TOTAL_BLOCKS)) ?
            CNT_W'(bpa_pkg::TOTAL_BLOCKS) : CNT_W'(max_q);
    room  = (managed_q < limit) ? (limit - managed_q) : '0;

    grow_add   = (32'(count_q) < 32'(room_q)) ? CNT_W'(count_q) : room_q;
    grow_end   = managed_q + grow_add;
    grow_start = IDX_W'(managed_q);

    fmt_word = fmt_n_q >> BIT_W;
    if (CNT_W'(word_q) < fmt_word) begin
      fmt_hi = RANGE_W'(bpa_pkg::WORD_W);
    end else if (CNT_W'(word_q) == fmt_word) begin
      fmt_hi = {1'b0, fmt_n_q[BIT_W-1:0]};
    end else begin
      fmt_hi = '0;
    end

    grow_lo = (word_q == idx_q[IDX_W-1:BIT_W]) ? {1'b0, idx_q[BIT_W-1:0]} : '0;
    grow_hi = (word_q == last_q[IDX_W-1:BIT_W]) ?
              (RANGE_W'(last_q[BIT_W-1:0]) + RANGE_W'(1)) : RANGE_W'(bpa_pkg::WORD_W);
  end

  // Word unit control and bitmap write enable
  always_comb begin
    wop.op = bpa_pkg::WOP_FILL;
    wop.lo = '0;
    wop.hi = '0;
    if (state_q == S_FMT) begin
      wop.hi = fmt_hi;
    end else if (state_q == S_RMW) begin
      if (is_grow) begin
        wop.op = bpa_pkg::WOP_CLR;
        wop.lo = grow_lo;
        wop.hi = grow_hi;
      end else begin
        wop.op = (cmd_q == bpa_pkg::CMD_FREE) ? bpa_pkg::WOP_CLR : bpa_pkg::WOP_SET;
        wop.lo = {1'b0, idx_q[BIT_W-1:0]};
        wop.hi = {1'b0, idx_q[BIT_W-1:0]} + RANGE_W'(1);
      end
    end

    bit_changed = (wop.op == bpa_pkg::WOP_SET) ? !wres.old_bit : wres.old_bit;

    mem_we = (state_q == S_INIT) || (state_q == S_FMT) ||
             ((state_q == S_RMW) && (is_grow || bit_changed));
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    idx_d        = idx_q;
    last_d       = last_q;
    cmd_d        = cmd_q;
    fmt_n_d      = fmt_n_q;
    count_d      = count_q;
    room_d       = room_q;
    base_d       = base_q;
    managed_d    = managed_q;
    free_d       = free_q;
    hint_d       = hint_q;
    hint_valid_d = hint_valid_q;
    max_d        = cfg_we_i ? cfg_wdata_i : max_q;
    status_d     = status_q;
    alloc_d      = alloc_q;
    surplus_d    = surplus_q;

    case (state_q)
      S_INIT: begin
        word_d = word_q + WADDR_W'(1);
        if (word_q == LAST_WORD) begin
          word_d  = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_i.command;
          count_d   = cmd_i.block_count;
          status_d  = bpa_pkg::ST_OK;
          alloc_d   = '0;
          surplus_d = '0;
          case (cmd_i.command)
            bpa_pkg::CMD_FORMAT: begin
              fmt_n_d      = fmt_n;
              managed_d    = fmt_n;
              free_d       = fmt_n;
              base_d       = cmd_i.page_number;
              hint_d       = '0;
              hint_valid_d = (fmt_n != '0);
              word_d       = '0;
              state_d      = S_FMT;
            end
            bpa_pkg::CMD_ALLOC: begin
              if (!hint_valid_q) begin
                status_d = bpa_pkg::ST_NO_FREE;
                state_d  = S_DONE;
              end else begin
                idx_d   = hint_q;
                word_d  = hint_q[IDX_W-1:BIT_W];
                alloc_d = base_q + 32'(hint_q) + 32'd1;
                state_d = S_RD;
              end
            end
            bpa_pkg::CMD_RESERVE, bpa_pkg::CMD_FREE: begin
              if (page_in_range) begin
                idx_d   = IDX_W'(page_off);
                word_d  = page_off[IDX_W-1:BIT_W];
                state_d = S_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            bpa_pkg::CMD_GROW: begin
              state_d = S_GROOM;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_FMT: begin
        word_d = word_q + WADDR_W'(1);
        if (word_q == LAST_WORD) begin
          state_d = S_DONE;
        end
      end

      S_GROOM: begin
        room_d  = room;
        state_d = S_GSET;
      end

      S_GSET: begin
        surplus_d = count_q - bpa_pkg::BCNT_W'(grow_add);
        if (grow_add == '0) begin
          state_d = S_DONE;
        end else begin
          idx_d     = grow_start;
          last_d    = IDX_W'(grow_end - CNT_W'(1));
          word_d    = grow_start[IDX_W-1:BIT_W];
          managed_d = grow_end;
          free_d    = free_q + grow_add;
          // blocks above the managed count are always used, so the new
          // range only matters for the hint when nothing was free before
          if (!hint_valid_q) begin
            hint_d       = grow_start;
            hint_valid_d = 1'b1;
          end
          state_d = S_RD;
        end
      end

      S_RD: begin
        state_d = S_RMW;
      end

      S_RMW: begin
        state_d = S_DONE;
        if (is_grow) begin
          if (word_q != last_q[IDX_W-1:BIT_W]) begin
            word_d  = word_q + WADDR_W'(1);
            state_d = S_RD;
          end
        end else if (bit_changed) begin
          if (wop.op == bpa_pkg::WOP_SET) begin
            if (free_q != '0) begin
              free_d = free_q - CNT_W'(1);
            end
            // took the lowest free block: rescan from its word
            if (hint_valid_q && (idx_q == hint_q)) begin
              state_d = S_SCAN_RD;
            end
          end else begin
            free_d = free_q + CNT_W'(1);
            if (!hint_valid_q || (idx_q < hint_q)) begin
              hint_d       = idx_q;
              hint_valid_d = 1'b1;
            end
          end
        end
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (wres.any_zero) begin
          hint_d       = {word_q, wres.zero_pos};
          hint_valid_d = 1'b1;
          state_d      = S_DONE;
        end else if (word_q == LAST_WORD) begin
          hint_d       = '0;
          hint_valid_d = 1'b0;
          state_d      = S_DONE;
        end else begin
          word_d  = word_q + WADDR_W'(1);
          state_d = S_SCAN_RD;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      word_q       <= '0;
      managed_q    <= '0;
      free_q       <= '0;
      hint_q       <= '0;
      hint_valid_q <= 1'b0;
      base_q       <= '0;
      max_q        <= bpa_pkg::MAX_BLOCKS_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      word_q       <= word_d;
      managed_q    <= managed_d;
      free_q       <= free_d;
      hint_q       <= hint_d;
      hint_valid_q <= hint_valid_d;
      base_q       <= base_d;
      max_q        <= max_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    last_q    <= last_d;
    cmd_q     <= cmd_d;
    fmt_n_q   <= fmt_n_d;
    count_q   <= count_d;
    room_q    <= room_d;
    status_q  <= status_d;
    alloc_q   <= alloc_d;
    surplus_q <= surplus_d;
    if (out_load) begin
      out_status_q  <= status_q;
      out_alloc_q   <= alloc_q;
      out_surplus_q <= surplus_q;
      out_free_q    <= bpa_pkg::FREE_W'(free_q);
      out_next_q    <= hint_valid_q ? bpa_pkg::NEXT_W'(hint_q) : '0;
      out_none_q    <= !hint_valid_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.allocated_page = out_alloc_q;
  assign rsp_o.surplus_blocks = out_surplus_q;
  assign rsp_o.free_count     = out_free_q;
  assign rsp_o.next_free      = out_next_q;
  assign rsp_o.none_free      = out_none_q;

  // Free blocks all lie inside the managed range
  assert property (@(posedge clk_i) disable iff (!rst_ni) free_q <= managed_q)
    else $error("free count exceeds managed count");

  // The hint always points inside the managed range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_valid_q |-> (CNT_W'(hint_q) < managed_q))
    else $error("next-free hint outside managed range");

  // Between commands, a valid hint and a nonzero free count go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (hint_valid_q == (free_q != '0)))
    else $error("hint valid disagrees with free count");

  // A result word only appears after the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside finish state");

endmodule

FILE: bench/bitmap_page_allocator_core_tb.sv
// Self-checking bench for bitmap_page_allocator_core: directed and random commands,
// each result word checked against an in-bench bitmap allocator predictor.
// Depends on bpa_pkg, bpa_cmd_if, bpa_rsp_if and the core RTL.
module bitmap_page_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 22;
  localparam int MAX_REPORTS   = 10;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 50;

  localparam logic [bpa_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [bpa_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    bpa_pkg::status_e           status;
    logic [bpa_pkg::PAGE_W-1:0] allocated_page;
    logic [bpa_pkg::BCNT_W-1:0] surplus_blocks;
    logic [bpa_pkg::FREE_W-1:0] free_count;
    logic [bpa_pkg::NEXT_W-1:0] next_free;
    logic                       none_free;
  } alloc_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we;
  logic [bpa_pkg::MAXB_W-1:0] cfg_wdata;
  bit                         throttle = 1'b1;
  int                         fault_count = 0;

  alloc_result_t expected_results[$];

  // Predictor state
  logic [bpa_pkg::WORD_W-1:0] usage_map [bpa_pkg::BITMAP_WORDS];
  int unsigned                free_blocks;
  int unsigned                managed_blocks;
  int unsigned                first_free;
  bit                         first_free_ok;
  logic [bpa_pkg::PAGE_W-1:0] base_page;
  int unsigned                grow_limit;

  bpa_cmd_if cmd_if ();
  bpa_rsp_if rsp_if ();

  bitmap_page_allocator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The free count follows only real bit changes
  function automatic void mark_block(int unsigned idx, bit used);
    int unsigned w;
    int unsigned b;
    w = (idx >> 5) % bpa_pkg::BITMAP_WORDS;
    b = idx & 31;
    if (usage_map[w][b] == used) return;
    usage_map[w][b] = used;
    if (used) begin
      if (free_blocks > 0) free_blocks--;
    end else begin
      free_blocks++;
    end
  endfunction

  function automatic void find_first_free();
    first_free_ok = 1'b0;
    first_free    = 0;
    for (int w = 0; w < bpa_pkg::BITMAP_WORDS; w++) begin
      if (usage_map[w] != '1) begin
        for (int b = bpa_pkg::WORD_W - 1; b >= 0; b--)
          if (!usage_map[w][b]) first_free = w * bpa_pkg::WORD_W + b;
        first_free_ok = 1'b1;
        return;
      end
    end
  endfunction

  function automatic alloc_result_t predict_allocator(logic [bpa_pkg::CMD_W-1:0] cmd,
                                                      logic [bpa_pkg::PAGE_W-1:0] page,
                                                      logic [bpa_pkg::BCNT_W-1:0] count);
    alloc_result_t              r;
    int unsigned                n;
    int unsigned                lim;
    int unsigned                room;
    int unsigned                add;
    logic [bpa_pkg::PAGE_W-1:0] idx;
    r = '0;
    case (cmd)
      bpa_pkg::CMD_FORMAT: begin
        n = (32'(count) > bpa_pkg::TOTAL_BLOCKS) ? bpa_pkg::TOTAL_BLOCKS : 32'(count);
        for (int w = 0; w < bpa_pkg::BITMAP_WORDS; w++)
          for (int b = 0; b < bpa_pkg::WORD_W; b++)
            usage_map[w][b] = (w * bpa_pkg::WORD_W + b >= n);
        free_blocks    = n;
        managed_blocks = n;
        base_page      = page;
      end
      bpa_pkg::CMD_ALLOC: begin
        if (!first_free_ok) begin
          r.status = bpa_pkg::ST_NO_FREE;
        end else begin
          mark_block(first_free, 1'b1);
          r.allocated_page = base_page + 1 + first_free;
        end
      end
      bpa_pkg::CMD_RESERVE, bpa_pkg::CMD_FREE: begin
        idx = page - base_page - 1;
        if (idx < managed_blocks) mark_block(idx, cmd == bpa_pkg::CMD_RESERVE);
      end
      bpa_pkg::CMD_GROW: begin
        lim  = (grow_limit > bpa_pkg::TOTAL_BLOCKS) ? bpa_pkg::TOTAL_BLOCKS : grow_limit;
        room = (managed_blocks < lim) ? lim - managed_blocks : 0;
        add  = (32'(count) < room) ? 32'(count) : room;
        for (int unsigned i = 0; i < add; i++) mark_block(managed_blocks + i, 1'b0);
        managed_blocks += add;
        r.surplus_blocks = bpa_pkg::BCNT_W'(32'(count) - add);
      end
      default: ;
    endcase
    find_first_free();
    r.free_count = bpa_pkg::FREE_W'(free_blocks);
    r.next_free  = first_free_ok ? bpa_pkg::NEXT_W'(first_free) : '0;
    r.none_free  = !first_free_ok;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_cmd(logic [bpa_pkg::CMD_W-1:0] cmd, logic [bpa_pkg::PAGE_W-1:0] page,
                          logic [bpa_pkg::BCNT_W-1:0] count);
    if (throttle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        cmd_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= cmd;
    cmd_if.page_number <= page;
    cmd_if.block_count <= count;
    do @(posedge clk_i); while (!cmd_if.ready);
    expected_results.push_back(predict_allocator(cmd, page, count));
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every pending result word is back
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_grow_limit(logic [bpa_pkg::MAXB_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    grow_limit = 32'(value);
  endtask

  task automatic test_directed();
    send_cmd(bpa_pkg::CMD_ALLOC, '0, '0);
    send_cmd(bpa_pkg::CMD_RESERVE, '0, '0);
    send_cmd(CMD_UNKNOWN_HI, '1, '1);
    // Base near the top of the page space: indexes wrap around
    send_cmd(bpa_pkg::CMD_FORMAT, 32'hFFFF_FFF0, '0);
    send_cmd(bpa_pkg::CMD_GROW, '0, 16'd3);
    repeat (4) send_cmd(bpa_pkg::CMD_ALLOC, '0, '0);
    send_cmd(bpa_pkg::CMD_FREE, 32'hFFFF_FFF2, '0);
    send_cmd(bpa_pkg::CMD_FREE, 32'hFFFF_FFF2, '0);
    send_cmd(bpa_pkg::CMD_RESERVE, 32'hFFFF_FFF3, '0);
    send_cmd(bpa_pkg::CMD_RESERVE, 32'hFFFF_FFF0, '0);
    send_cmd(bpa_pkg::CMD_FREE, 32'hFFFF_FFF4, '0);
    // Oversized format, then grow with no room left
    send_cmd(bpa_pkg::CMD_FORMAT, 32'hAAAA_5555, '1);
    send_cmd(bpa_pkg::CMD_GROW, '0, 16'd5);
    send_cmd(bpa_pkg::CMD_GROW, '0, '1);
    send_cmd(bpa_pkg::CMD_ALLOC, '0, '0);
    send_cmd(bpa_pkg::CMD_RESERVE, 32'hAAAA_5555 + bpa_pkg::TOTAL_BLOCKS, '0);
    send_cmd(bpa_pkg::CMD_FREE, 32'hAAAA_5555 + bpa_pkg::TOTAL_BLOCKS, '0);
    send_cmd(bpa_pkg::CMD_FREE, 32'hAAAA_5556, '0);
    send_cmd(CMD_UNKNOWN_LO, 32'h5555_AAAA, 16'h5555);
    send_cmd(CMD_UNKNOWN_LO + 3'd1, 32'h5555_AAAA, 16'hAAAA);
    send_cmd(bpa_pkg::CMD_FORMAT, 32'h5555_AAAA, 16'd40);
    send_cmd(bpa_pkg::CMD_GROW, '0, '0);
    send_cmd(bpa_pkg::CMD_ALLOC, '0, '0);
  endtask

  task automatic test_random_phase(int items, logic [bpa_pkg::MAXB_W-1:0] limit, bit steady);
    int                         pick;
    logic [bpa_pkg::BCNT_W-1:0] count;
    logic [bpa_pkg::PAGE_W-1:0] page;
    write_grow_limit(limit);
    throttle = !steady;
    send_cmd(bpa_pkg::CMD_FORMAT, $urandom(), 16'($urandom_range(1, 160)));
    for (int k = 1; k < items; k++) begin
      if ($urandom_range(0, 199) == 0) settle();
      pick = $urandom_range(0, 99);
      if (managed_blocks > 0) page = base_page + 1 + $urandom_range(0, managed_blocks - 1);
      else page = $urandom();
      if (pick < 3) begin
        count = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 200));
        send_cmd(bpa_pkg::CMD_FORMAT, $urandom(), count);
      end else if (pick < 40) begin
        send_cmd(bpa_pkg::CMD_ALLOC, $urandom(), 16'($urandom()));
      end else if (pick < 75) begin
        send_cmd((pick < 55) ? bpa_pkg::CMD_RESERVE : bpa_pkg::CMD_FREE, page,
                 16'($urandom()));
      end else if (pick < 84) begin
        count = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 48));
        send_cmd(bpa_pkg::CMD_GROW, $urandom(), count);
      end else if (pick < 88) begin
        send_cmd(bpa_pkg::CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)),
                 $urandom(), 16'($urandom()));
      end else begin
        send_cmd((pick < 94) ? bpa_pkg::CMD_RESERVE : bpa_pkg::CMD_FREE, $urandom(),
                 16'($urandom()));
      end
    end
    throttle = 1'b1;
  endtask

  always @(negedge clk_i) begin
    rsp_if.ready <= throttle ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  always @(posedge clk_i) begin
    alloc_result_t seen;
    alloc_result_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      seen.status         = bpa_pkg::status_e'(rsp_if.status);
      seen.allocated_page = rsp_if.allocated_page;
      seen.surplus_blocks = rsp_if.surplus_blocks;
      seen.free_count     = rsp_if.free_count;
      seen.next_free      = rsp_if.next_free;
      seen.none_free      = rsp_if.none_free;
      if (expected_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: result word with nothing pending: %p", $realtime, seen);
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                     $realtime, want, seen);
        end
      end
    end
  end

  // End the run when no word moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = '0;
    cmd_if.page_number = '0;
    cmd_if.block_count = '0;
    rsp_if.ready       = 1'b0;
    for (int w = 0; w < bpa_pkg::BITMAP_WORDS; w++) usage_map[w] = '1;
    free_blocks    = 0;
    managed_blocks = 0;
    first_free     = 0;
    first_free_ok  = 1'b0;
    base_page      = '0;
    grow_limit     = 32'(bpa_pkg::MAX_BLOCKS_RST);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_phase(265, 16'd1, 1'b0);
    test_random_phase(265, 16'hFFFF, 1'b0);
    test_random_phase(265, bpa_pkg::MAX_BLOCKS_RST, 1'b1);
    test_random_phase(265, 16'($urandom_range(1, 65535)), 1'b0);
    test_random_phase(265, 16'd200, 1'b0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
